// ===== hdl/koch_curve_point_generator_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Koch curve point generator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef KOCH_CURVE_POINT_GENERATOR_UNIT_ASSERT_SVH
`define KOCH_CURVE_POINT_GENERATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KCPG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KCPG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/kcpg_pkg.sv =====
// ---------------------------------------------------------------------------
// Koch curve point generator package
// Widths, constants and shared types of the point generator.
// ---------------------------------------------------------------------------
package kcpg_pkg;

	// Field and datapath widths.
	localparam int COORD_W   = 32;
	localparam int EXT_W     = COORD_W + 2;
	localparam int MAG_W     = COORD_W;
	localparam int PROD_W    = 2 * MAG_W;
	localparam int DEPTH_W   = 3;
	localparam int IDX_W     = 12;
	localparam int MAX_DEPTH = 6;

	localparam logic [DEPTH_W-1:0] MAX_DEPTH_CODE = DEPTH_W'(MAX_DEPTH);

	// Reciprocal of three: floor(m / 3) = (m * RECIP3) >> RECIP_SHIFT for m < 2^32.
	localparam logic [MAG_W-1:0] RECIP3      = 32'hAAAA_AAAB;
	localparam int               RECIP_SHIFT = 33;

	// sqrt(3)/6 as a 24-bit fraction.
	localparam logic [MAG_W-1:0] KOCH_K     = 32'd4843165;
	localparam int               KOCH_SHIFT = 24;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [EXT_W-1:0]   ext_t;
	typedef logic        [MAG_W-1:0]   mag_t;
	typedef logic        [PROD_W-1:0]  prod_t;

	// Constant operand of the shared multiplier.
	typedef enum logic [0:0] {
		MC_RECIP3,
		MC_KOCH
	} mul_const_t;

	// Base-4 digit of the point index: which of the four pieces is kept.
	typedef enum logic [1:0] {
		DIG_FIRST = 2'd0,
		DIG_RISE  = 2'd1,
		DIG_FALL  = 2'd2,
		DIG_LAST  = 2'd3
	} digit_t;

	// Current segment.
	typedef struct packed {
		coord_t x1;
		coord_t y1;
		coord_t x2;
		coord_t y2;
	} seg_t;

	// Terms gathered over one subdivision level.
	typedef struct packed {
		mag_t   q_dx;
		logic   r2_dx;
		logic   neg_dx;
		mag_t   q_dy;
		logic   r2_dy;
		logic   neg_dy;
		mag_t   k_dx;
		mag_t   k_dy;
		coord_t mid_x;
		coord_t mid_y;
	} terms_t;

endpackage

// ===== hdl/koch_curve_point_generator_unit.sv =====
// The result word is registered in ST_DONE once L levels are worked, where L is the depth
// limited to six; an out-of-range index or a zero depth goes from ST_IDLE straight to ST_DONE.
// No new word is accepted until the result leaves ST_DONE, which holds while pt_stall blocks it.
// Each level takes six steps: a difference step, four passes through the one shared
// 32x32 multiplier (two thirds, two apex offsets) and an update step.
// Reset clears the sequencer and the output valid; the block is ready in the first cycle.
// ---------------------------------------------------------------------------
// Koch curve point generator
// Walks the base-4 digits of a point index down the Koch construction over a
// segment and returns the end point of the indexed sub-segment.
// ---------------------------------------------------------------------------
module koch_curve_point_generator_unit
	import kcpg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               seg_valid,
	output logic               seg_stall,
	input  coord_t             x_start,
	input  coord_t             y_start,
	input  coord_t             x_end,
	input  coord_t             y_end,
	input  logic [DEPTH_W-1:0] depth,
	input  logic [IDX_W-1:0]   point_index,
	output logic               pt_valid,
	input  logic               pt_stall,
	output coord_t             point_x,
	output coord_t             point_y,
	output logic               index_too_large
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_M0,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_UPD,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [DEPTH_W-1:0] lvl_q;
	logic               flag_q;
	seg_t               seg_q;
	terms_t             terms_q;
	logic [IDX_W-1:0]   idx_q;
	mag_t               mag_dx_q;
	mag_t               mag_dy_q;

	logic               accept;
	logic [DEPTH_W-1:0] depth_clamp;
	logic               too_large;
	logic [DEPTH_W-1:0] lvl_m1;
	digit_t             digit;
	ext_t               dx_w;
	ext_t               dy_w;
	ext_t               adx_w;
	ext_t               ady_w;
	ext_t               sum_x;
	ext_t               sum_y;
	ext_t               half_x;
	ext_t               half_y;
	mag_t               mul_mag;
	mul_const_t         mul_sel;
	prod_t              prod_q;
	mag_t               quot;
	mag_t               rem_mag;
	logic [MAG_W+1:0]   rem;
	logic               rem_is2;
	mag_t               kprod;
	terms_t             terms_w;
	seg_t               nxt_seg;

	// Input handshake: one word at a time.
	assign seg_stall = (state_q != ST_IDLE);
	assign accept    = seg_valid && !seg_stall;

	// Depth limit and index range check.
	assign depth_clamp = (depth > MAX_DEPTH_CODE) ? MAX_DEPTH_CODE : depth;
	assign too_large   = (point_index >> {depth_clamp, 1'b0}) != '0;

	// Digit of the current level, most significant first.
	assign lvl_m1 = lvl_q - DEPTH_W'(1);
	assign digit  = digit_t'(idx_q[{lvl_m1, 1'b0} +: 2]);

	// Differences, magnitudes and midpoints truncated toward zero.
	assign dx_w   = ext_t'(seg_q.x2) - ext_t'(seg_q.x1);
	assign dy_w   = ext_t'(seg_q.y2) - ext_t'(seg_q.y1);
	assign adx_w  = dx_w[EXT_W-1] ? -dx_w : dx_w;
	assign ady_w  = dy_w[EXT_W-1] ? -dy_w : dy_w;
	assign sum_x  = ext_t'(seg_q.x1) + ext_t'(seg_q.x2);
	assign sum_y  = ext_t'(seg_q.y1) + ext_t'(seg_q.y2);
	assign half_x = (sum_x + ext_t'({1'b0, sum_x[EXT_W-1]})) >>> 1;
	assign half_y = (sum_y + ext_t'({1'b0, sum_y[EXT_W-1]})) >>> 1;

	// Operand schedule of the shared multiplier.
	always_comb begin
		unique case (state_q)
			ST_M0: begin
				mul_mag = mag_dx_q;
				mul_sel = MC_RECIP3;
			end
			ST_M1: begin
				mul_mag = mag_dy_q;
				mul_sel = MC_RECIP3;
			end
			ST_M2: begin
				mul_mag = mag_dy_q;
				mul_sel = MC_KOCH;
			end
			ST_M3: begin
				mul_mag = mag_dx_q;
				mul_sel = MC_KOCH;
			end
			default: begin
				mul_mag = mag_dx_q;
				mul_sel = MC_RECIP3;
			end
		endcase
	end

	kcpg_mul u_mul (
		.clk    (clk),
		.mag    (mul_mag),
		.sel    (mul_sel),
		.prod_q (prod_q)
	);

	// Quotient by three and a check for a remainder of two.
	assign quot    = {1'b0, prod_q[PROD_W-1:RECIP_SHIFT]};
	assign rem_mag = (state_q == ST_M1) ? mag_dx_q : mag_dy_q;
	assign rem     = {2'b00, rem_mag} - ({1'b0, quot, 1'b0} + {2'b00, quot});
	assign rem_is2 = (rem == (MAG_W+2)'(2));

	// Scaled perpendicular offset.
	assign kprod = prod_q[KOCH_SHIFT +: MAG_W];

	// Terms of the level, with the last product taken straight from the multiplier.
	always_comb begin
		terms_w      = terms_q;
		terms_w.k_dx = kprod;
	end

	kcpg_upd u_upd (
		.seg   (seg_q),
		.terms (terms_w),
		.digit (digit),
		.nxt   (nxt_seg)
	);

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			lvl_q           <= '0;
			flag_q          <= 1'b0;
			pt_valid        <= 1'b0;
			point_x         <= '0;
			point_y         <= '0;
			index_too_large <= 1'b0;
		end else begin
			if (pt_valid && !pt_stall && state_q != ST_DONE) begin
				pt_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (seg_valid) begin
						lvl_q  <= depth_clamp;
						flag_q <= too_large;
						if (too_large || depth_clamp == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_DIFF;
						end
					end
				end
				ST_DIFF: state_q <= ST_M0;
				ST_M0:   state_q <= ST_M1;
				ST_M1:   state_q <= ST_M2;
				ST_M2:   state_q <= ST_M3;
				ST_M3:   state_q <= ST_UPD;
				ST_UPD: begin
					if (lvl_q == DEPTH_W'(1)) begin
						state_q <= ST_DONE;
					end else begin
						lvl_q   <= lvl_m1;
						state_q <= ST_DIFF;
					end
				end
				ST_DONE: begin
					if (!pt_valid || !pt_stall) begin
						pt_valid        <= 1'b1;
						point_x         <= seg_q.x2;
						point_y         <= seg_q.y2;
						index_too_large <= flag_q;
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Segment and level terms.
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q    <= point_index;
			seg_q.x1 <= x_start;
			seg_q.y1 <= y_start;
			seg_q.x2 <= too_large ? coord_t'(0) : x_end;
			seg_q.y2 <= too_large ? coord_t'(0) : y_end;
		end
		if (state_q == ST_DIFF) begin
			mag_dx_q       <= adx_w[MAG_W-1:0];
			mag_dy_q       <= ady_w[MAG_W-1:0];
			terms_q.neg_dx <= dx_w[EXT_W-1];
			terms_q.neg_dy <= dy_w[EXT_W-1];
			terms_q.mid_x  <= half_x[COORD_W-1:0];
			terms_q.mid_y  <= half_y[COORD_W-1:0];
		end
		if (state_q == ST_M1) begin
			terms_q.q_dx  <= quot;
			terms_q.r2_dx <= rem_is2;
		end
		if (state_q == ST_M2) begin
			terms_q.q_dy  <= quot;
			terms_q.r2_dy <= rem_is2;
		end
		if (state_q == ST_M3) begin
			terms_q.k_dy <= kprod;
		end
		if (state_q == ST_M0) begin
			terms_q.k_dx <= terms_q.k_dx;
		end
		if (state_q == ST_UPD) begin
			seg_q <= nxt_seg;
		end
	end

	`include "koch_curve_point_generator_unit_assert.svh"

	`KCPG_ASSERT_NEXT(a_skip, accept && too_large, state_q == ST_DONE && flag_q, "range skip")
	`KCPG_ASSERT_NOW(a_lvl, state_q == ST_DIFF, lvl_q != '0 && lvl_q <= MAX_DEPTH_CODE, "level")
	`KCPG_ASSERT_NEXT(a_out, state_q == ST_DONE && !pt_stall, pt_valid && state_q == ST_IDLE, "out")
	`KCPG_ASSERT_NOW(a_flag, pt_valid && index_too_large, point_x == '0 && point_y == '0, "flag")

endmodule

// ===== hdl/kcpg_mul.sv =====
// ---------------------------------------------------------------------------
// Koch curve point generator shared multiplier
// Unsigned 32x32 product of a magnitude and a selected constant, registered.
// ---------------------------------------------------------------------------
module kcpg_mul
	import kcpg_pkg::*;
(
	input  logic       clk,
	input  mag_t       mag,
	input  mul_const_t sel,
	output prod_t      prod_q
);

	mag_t cval;

	// Pick the constant operand.
	always_comb begin
		unique case (sel)
			MC_RECIP3: cval = RECIP3;
			MC_KOCH:   cval = KOCH_K;
			default:   cval = RECIP3;
		endcase
	end

	// Registered product.
	always_ff @(posedge clk) begin
		prod_q <= {{MAG_W{1'b0}}, mag} * {{MAG_W{1'b0}}, cval};
	end

endmodule

// ===== hdl/kcpg_upd.sv =====
// ---------------------------------------------------------------------------
// Koch curve point generator level update
// Forms the division points and the apex and keeps the piece the digit picks.
// ---------------------------------------------------------------------------
module kcpg_upd
	import kcpg_pkg::*;
(
	input  seg_t   seg,
	input  terms_t terms,
	input  digit_t digit,
	output seg_t   nxt
);

	// Clamp a wide value to the coordinate range.
	function automatic coord_t sat_coord(input ext_t v);
		coord_t r;
		if (&v[EXT_W-1:COORD_W-1] || ~|v[EXT_W-1:COORD_W-1]) begin
			r = v[COORD_W-1:0];
		end else if (v[EXT_W-1]) begin
			r = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_W-1){1'b1}}};
		end
		return r;
	endfunction

	// Give a magnitude its sign back, truncation toward zero kept.
	function automatic ext_t signed_term(input logic neg, input mag_t m);
		ext_t e;
		e = ext_t'({2'b00, m});
		return neg ? -e : e;
	endfunction

	mag_t   q2_dx;
	mag_t   q2_dy;
	coord_t p1x;
	coord_t p1y;
	coord_t p2x;
	coord_t p2y;
	coord_t ax;
	coord_t ay;

	// Two thirds from the one third and its remainder.
	assign q2_dx = {terms.q_dx[MAG_W-2:0], 1'b0} + mag_t'(terms.r2_dx);
	assign q2_dy = {terms.q_dy[MAG_W-2:0], 1'b0} + mag_t'(terms.r2_dy);

	// Division points at one and two thirds.
	assign p1x = sat_coord(ext_t'(seg.x1) + signed_term(terms.neg_dx, terms.q_dx));
	assign p1y = sat_coord(ext_t'(seg.y1) + signed_term(terms.neg_dy, terms.q_dy));
	assign p2x = sat_coord(ext_t'(seg.x1) + signed_term(terms.neg_dx, q2_dx));
	assign p2y = sat_coord(ext_t'(seg.y1) + signed_term(terms.neg_dy, q2_dy));

	// Apex off the midpoint along the perpendicular.
	assign ax = sat_coord(ext_t'(terms.mid_x) + signed_term(terms.neg_dy, terms.k_dy));
	assign ay = sat_coord(ext_t'(terms.mid_y) - signed_term(terms.neg_dx, terms.k_dx));

	// Keep the selected piece.
	always_comb begin
		nxt = seg;
		unique case (digit)
			DIG_FIRST: begin
				nxt.x2 = p1x;
				nxt.y2 = p1y;
			end
			DIG_RISE: begin
				nxt.x1 = p1x;
				nxt.y1 = p1y;
				nxt.x2 = ax;
				nxt.y2 = ay;
			end
			DIG_FALL: begin
				nxt.x1 = ax;
				nxt.y1 = ay;
				nxt.x2 = p2x;
				nxt.y2 = p2y;
			end
			DIG_LAST: begin
				nxt.x1 = p2x;
				nxt.y1 = p2y;
			end
			default: nxt = seg;
		endcase
	end

endmodule
